>>> hw/rtl/phcv_pkg.sv
// Shared types, constants and helpers for the packet header checksum validator.
// No dependencies; imported by the channel interfaces and the core.
package phcv_pkg;

    localparam int BYTE_W       = 8;
    localparam int ERR_W        = 3;
    localparam int PKT_NUM_W    = 32;
    localparam int WORD_W       = 16;
    localparam int HDR_BYTES    = 8;

    localparam logic [BYTE_W-1:0] MAGIC_RESET = 8'hCC;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_MAGIC    = 3'd1,
        ERR_OPTIONS  = 3'd2,
        ERR_CHECKSUM = 3'd3,
        ERR_PADDING  = 3'd4,
        ERR_LENGTH   = 3'd5
    } phcv_err_t;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0]   s;
        logic [WORD_W:0]   t;
        s = {1'b0, a} + {1'b0, b};
        t = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
        return t[WORD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/phcv_ifs.sv
// Valid/ready channel interfaces for the validator: byte input, verdict output,
// and magic register write. Depends on phcv_pkg for field widths.
interface phcv_byte_if;
    import phcv_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_byte;
    logic              last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface phcv_verdict_if;
    import phcv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 valid_res;
    logic [ERR_W-1:0]     error_code;
    logic [PKT_NUM_W-1:0] packet_number;

    modport source (output valid, output valid_res, output error_code,
                    output packet_number, input ready);
    modport sink   (input valid, input valid_res, input error_code,
                    input packet_number, output ready);
endinterface

interface phcv_cfg_if;
    import phcv_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] magic_value;

    modport source (output valid, output magic_value, input ready);
    modport sink   (input valid, input magic_value, output ready);
endinterface

>>> hw/rtl/packet_header_checksum_validator_core.sv
// Packet header checksum validator: one byte beat per cycle while the skid entry is
// empty, one verdict beat per packet, registered from the beat carrying the last byte.
// Throughput is set by the single 16-bit end-around-carry adder that updates the
//   running sum; a two-entry output buffer absorbs verdict stalls.
// Reset (rst_n low, asynchronous): packet state and packet counter clear, magic_value
//   returns to 0xCC, output buffer empties. Depends on phcv_pkg and phcv_ifs.
module packet_header_checksum_validator_core #(
    parameter int unsigned MAX_PACKET_BYTES = 262144
) (
    input  logic                  clk,
    input  logic                  rst_n,
    phcv_byte_if.sink             pkt,
    phcv_verdict_if.source        verdict,
    phcv_cfg_if.sink              cfg
);
    import phcv_pkg::*;

    // Byte counter must hold MAX_PACKET_BYTES itself (saturation value)
    localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
    // Length compare width: wide enough for both the count and the 16-bit field
    localparam int CMP_W = (IDX_W > WORD_W) ? IDX_W : WORD_W;

    typedef struct packed {
        logic                 valid_res;
        logic [ERR_W-1:0]     error_code;
        logic [PKT_NUM_W-1:0] packet_number;
    } result_t;

    // Packet state
    logic [IDX_W-1:0]     byte_index_reg;
    logic [WORD_W-1:0]    sum_reg;
    logic [BYTE_W-1:0]    pending_high_reg;
    logic [WORD_W-1:0]    rx_checksum_reg;
    logic [WORD_W-1:0]    decl_length_reg;
    phcv_err_t            first_error_reg;
    logic                 sensitive_reg;
    logic [PKT_NUM_W-1:0] packet_counter_reg;
    logic [BYTE_W-1:0]    magic_reg;

    // Output buffer: main register plus skid
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    logic pkt_fire;
    logic out_fire;

    // Per-beat datapath
    logic [IDX_W-1:0]     pos;
    logic                 take;
    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    sum_byte;
    logic [IDX_W-1:0]     count;
    logic                 pair_add;
    logic                 pad_add;
    logic [WORD_W-1:0]    add_operand;
    logic [WORD_W-1:0]    sum_after;
    logic [BYTE_W-1:0]    pending_after;
    logic [WORD_W-1:0]    rx_checksum_after;
    logic [WORD_W-1:0]    decl_length_after;
    phcv_err_t            first_error_after;
    logic                 sensitive_after;
    logic [CMP_W-1:0]     payload_count;
    phcv_err_t            verdict_err;
    result_t              result;

    assign pkt.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign pkt_fire  = pkt.valid && pkt.ready;
    assign out_fire  = out_valid_reg && verdict.ready;

    assign verdict.valid         = out_valid_reg;
    assign verdict.valid_res     = out_data_reg.valid_res;
    assign verdict.error_code    = out_data_reg.error_code;
    assign verdict.packet_number = out_data_reg.packet_number;

    assign pos  = byte_index_reg;
    assign b    = pkt.packet_byte;
    // Drop bytes past the size limit: not checked, not summed
    assign take = (pos < IDX_W'(MAX_PACKET_BYTES));

    always_comb
    begin
        sum_byte          = b;
        rx_checksum_after = rx_checksum_reg;
        decl_length_after = decl_length_reg;
        first_error_after = first_error_reg;
        sensitive_after   = sensitive_reg;

        if (take)
        begin
            if (pos == IDX_W'(0))
            begin
                if (b != magic_reg && first_error_reg == ERR_NONE)
                    first_error_after = ERR_MAGIC;
            end
            else if (pos == IDX_W'(1))
            begin
                sensitive_after = b[6];
                if (b[5:0] != 6'd0 && first_error_reg == ERR_NONE)
                    first_error_after = ERR_OPTIONS;
            end
            else if (pos == IDX_W'(2))
                decl_length_after = {b, decl_length_reg[BYTE_W-1:0]};
            else if (pos == IDX_W'(3))
                decl_length_after = {decl_length_reg[WORD_W-1:BYTE_W], b};
            else if (pos == IDX_W'(4))
            begin
                rx_checksum_after = {b, rx_checksum_reg[BYTE_W-1:0]};
                sum_byte          = magic_reg;
            end
            else if (pos == IDX_W'(5))
            begin
                rx_checksum_after = {rx_checksum_reg[WORD_W-1:BYTE_W], b};
                sum_byte          = magic_reg;
            end
            else if (pos == IDX_W'(6) || pos == IDX_W'(7))
            begin
                if (b != ZERO_BYTE && first_error_reg == ERR_NONE)
                    first_error_after = ERR_PADDING;
            end
        end
    end

    assign count         = take ? (pos + IDX_W'(1)) : pos;
    assign pending_after = (take && !pos[0]) ? sum_byte : pending_high_reg;

    // One adder serves both the word add on an odd byte and the zero-pad add for a
    // lone final byte; the two never fall in the same beat.
    assign pair_add    = take && pos[0];
    assign pad_add     = pkt.last_byte && count[0];
    assign add_operand = pair_add ? {pending_high_reg, sum_byte} : {pending_after, ZERO_BYTE};
    assign sum_after   = (pair_add || pad_add) ? oc_add(sum_reg, add_operand) : sum_reg;

    assign payload_count = CMP_W'(count) - CMP_W'(HDR_BYTES);

    always_comb
    begin
        if (first_error_after == ERR_MAGIC || first_error_after == ERR_OPTIONS)
            verdict_err = first_error_after;
        else if (sensitive_after && (~sum_after) != rx_checksum_after)
            verdict_err = ERR_CHECKSUM;
        else if (first_error_after == ERR_PADDING)
            verdict_err = ERR_PADDING;
        else if (count < IDX_W'(HDR_BYTES) || payload_count != CMP_W'(decl_length_after))
            verdict_err = ERR_LENGTH;
        else
            verdict_err = ERR_NONE;
    end

    assign result.valid_res     = (verdict_err == ERR_NONE);
    assign result.error_code    = verdict_err;
    assign result.packet_number = packet_counter_reg;

    // Packet state and register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg     <= '0;
            sum_reg            <= '0;
            pending_high_reg   <= '0;
            rx_checksum_reg    <= '0;
            decl_length_reg    <= '0;
            first_error_reg    <= ERR_NONE;
            sensitive_reg      <= 1'b0;
            packet_counter_reg <= '0;
            magic_reg          <= MAGIC_RESET;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                magic_reg <= cfg.magic_value;
            if (pkt_fire)
            begin
                if (pkt.last_byte)
                begin
                    // Clear for the next packet
                    byte_index_reg     <= '0;
                    sum_reg            <= '0;
                    pending_high_reg   <= '0;
                    rx_checksum_reg    <= '0;
                    decl_length_reg    <= '0;
                    first_error_reg    <= ERR_NONE;
                    sensitive_reg      <= 1'b0;
                    packet_counter_reg <= packet_counter_reg + PKT_NUM_W'(1);
                end
                else
                begin
                    byte_index_reg   <= count;
                    sum_reg          <= sum_after;
                    pending_high_reg <= pending_after;
                    rx_checksum_reg  <= rx_checksum_after;
                    decl_length_reg  <= decl_length_after;
                    first_error_reg  <= first_error_after;
                    sensitive_reg    <= sensitive_after;
                end
            end
        end
    end

    // Output buffer control: skid holds a verdict that arrives while the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= pkt_fire && pkt.last_byte;
            end
            else if (pkt_fire && pkt.last_byte)
            begin
                if (out_valid_reg)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (pkt_fire && pkt.last_byte)
                out_data_reg <= result;
        end
        else if (pkt_fire && pkt.last_byte)
        begin
            if (out_valid_reg)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for packet_header_checksum_validator_core: byte beats in, verdicts out.
// Needs phcv_pkg, the phcv channel interfaces and the core; nothing else.
module testbench;
    import phcv_pkg::*;

    localparam int unsigned MAX_BYTES    = 262144;
    localparam int          RUN_LIMIT    = 1200000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PHASE_BYTES  = 75;
    localparam int          HOLD_CYCLES  = 400;

    // One expected verdict beat
    typedef struct packed {
        logic            ok;
        phcv_err_t       code;
        logic [31:0]     num;
    } verdict_t;

    // Tracks the block's packet state and queues the verdict each final byte should produce.
    class verdict_board;
        logic [7:0]  magic;
        int unsigned count;
        logic [15:0] sum;
        logic [7:0]  hi_byte;
        logic [15:0] rx_ck;
        logic [15:0] decl_len;
        phcv_err_t   first_err;
        bit          sens;
        logic [31:0] pkt_num;
        verdict_t    due_verdicts [$];
        int          errors;
        int          code_hits [6];

        function new();
            magic   = MAGIC_RESET;
            pkt_num = '0;
            errors  = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
            clear();
        endfunction

        static function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
            logic [16:0] t;
            t = {1'b0, a} + {1'b0, b};
            return t[15:0] + {15'd0, t[16]};
        endfunction

        function void clear();
            count     = 0;
            sum       = '0;
            hi_byte   = '0;
            rx_ck     = '0;
            decl_len  = '0;
            first_err = ERR_NONE;
            sens      = 1'b0;
        endfunction

        function void flag(input phcv_err_t code);
            if (first_err == ERR_NONE) first_err = code;
        endfunction

        function void set_magic(input logic [7:0] v);
            magic = v;
        endfunction

        function int outstanding();
            return due_verdicts.size();
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            logic [7:0] s;
            phcv_err_t  e;
            verdict_t   v;
            // Bytes past the size cap are dropped; the count stays pinned.
            if (count < MAX_BYTES)
            begin
                s = b;
                case (count)
                    0: if (b != magic) flag(ERR_MAGIC);
                    1:
                    begin
                        sens = b[6];
                        if (b[5:0] != 6'd0) flag(ERR_OPTIONS);
                    end
                    2: decl_len[15:8] = b;
                    3: decl_len[7:0]  = b;
                    4:
                    begin
                        rx_ck[15:8] = b;
                        s = magic;
                    end
                    5:
                    begin
                        rx_ck[7:0] = b;
                        s = magic;
                    end
                    6, 7: if (b != ZERO_BYTE) flag(ERR_PADDING);
                    default: ;
                endcase
                if (count[0] == 1'b0) hi_byte = s;
                else sum = ones_add(sum, {hi_byte, s});
                count++;
            end
            if (!last) return;
            // Pad a lone final byte with a zero low byte
            if (count[0]) sum = ones_add(sum, {hi_byte, ZERO_BYTE});
            if (first_err == ERR_MAGIC || first_err == ERR_OPTIONS) e = first_err;
            else if (sens && (~sum) != rx_ck) e = ERR_CHECKSUM;
            else if (first_err == ERR_PADDING) e = ERR_PADDING;
            else if (count < HDR_BYTES || (count - HDR_BYTES) != {16'd0, decl_len})
                e = ERR_LENGTH;
            else e = ERR_NONE;
            v.ok   = (e == ERR_NONE);
            v.code = e;
            v.num  = pkt_num;
            due_verdicts.push_back(v);
            code_hits[int'(e)]++;
            pkt_num++;
            clear();
        endfunction

        function void check_verdict(input logic ok, input logic [2:0] code,
                                    input logic [31:0] num);
            verdict_t exp;
            if (due_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected verdict beat: valid_res=%0b error_code=%0d",
                         $time, ok, code);
                $display("%0t:   packet_number=%0d", $time, num);
                return;
            end
            exp = due_verdicts.pop_front();
            if (ok !== exp.ok)
            begin
                errors++;
                $display("%0t: packet %0d valid_res expected %0b actual %0b",
                         $time, exp.num, exp.ok, ok);
            end
            if (code !== exp.code)
            begin
                errors++;
                $display("%0t: packet %0d error_code expected %0d actual %0d",
                         $time, exp.num, exp.code, code);
            end
            if (num !== exp.num)
            begin
                errors++;
                $display("%0t: packet_number expected %0d actual %0d", $time, exp.num, num);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    phcv_byte_if    pkt_ch ();
    phcv_verdict_if vrd_ch ();
    phcv_cfg_if     cfg_ch ();

    packet_header_checksum_validator_core #(
        .MAX_PACKET_BYTES (MAX_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch),
        .verdict (vrd_ch),
        .cfg     (cfg_ch)
    );

    verdict_board sb;
    logic [7:0]   frame [$];       // bytes of the packet being built
    logic [7:0]   cur_magic;       // magic the stimulus builds packets for
    int           hold_left  = 0;  // long receiver hold-off, counted down by the receiver
    int           stall_left = 0;
    int           cycle_count;
    int           bytes_sent  = 0;
    int           frames_sent = 0;

    // Clock: 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: end the run if the drain never completes
    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d verdicts outstanding",
                 cycle_count, sb.outstanding());
        $display("DONE: errors detected");
        $finish;
    end

    // Monitor: sample every handshake at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_magic(cfg_ch.magic_value);
            if (pkt_ch.valid && pkt_ch.ready)
                sb.note_byte(pkt_ch.packet_byte, pkt_ch.last_byte);
            if (vrd_ch.valid && vrd_ch.ready)
                sb.check_verdict(vrd_ch.valid_res, vrd_ch.error_code, vrd_ch.packet_number);
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls on the verdict channel, plus a long hold-off on request.
    initial
    begin
        vrd_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                vrd_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                vrd_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                vrd_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_span();
            end
        end
    end

    // Fill the checksum field so the packet sums clean with bytes 4 and 5 as magic.
    function automatic void seal_checksum(input logic [7:0] mg);
        logic [15:0] acc;
        logic [7:0]  hi;
        logic [7:0]  s;
        acc = '0;
        hi  = '0;
        for (int i = 0; i < frame.size(); i++)
        begin
            s = (i == 4 || i == 5) ? mg : frame[i];
            if (i % 2 == 0) hi = s;
            else acc = verdict_board::ones_add(acc, {hi, s});
        end
        if (frame.size() % 2 == 1) acc = verdict_board::ones_add(acc, {hi, ZERO_BYTE});
        acc = ~acc;
        frame[4] = acc[15:8];
        frame[5] = acc[7:0];
    endfunction

    // Build a well-formed packet: header with matching length, random payload.
    task automatic build_frame(input logic [7:0] mg, input int plen, input bit sens,
                               input bit top_opt);
        logic [15:0] len16;
        len16 = plen[15:0];
        frame.delete();
        frame.push_back(mg);
        frame.push_back({top_opt, sens, 6'd0});
        frame.push_back(len16[15:8]);
        frame.push_back(len16[7:0]);
        repeat (4) frame.push_back(ZERO_BYTE);
        for (int i = 0; i < plen; i++) frame.push_back(8'($urandom_range(0, 255)));
        if (sens) seal_checksum(mg);
    endtask

    // Drive the current packet one beat at a time; steady means no idle cycles.
    task automatic send_frame(input bit steady);
        int gap;
        for (int i = 0; i < frame.size(); i++)
        begin
            gap = steady ? 0 : idle_span();
            repeat (gap)
            begin
                @(negedge clk);
                pkt_ch.valid <= 1'b0;
            end
            @(negedge clk);
            pkt_ch.valid       <= 1'b1;
            pkt_ch.packet_byte <= frame[i];
            pkt_ch.last_byte   <= (i == frame.size() - 1);
            do @(posedge clk); while (pkt_ch.ready !== 1'b1);
        end
        bytes_sent += frame.size();
        frames_sent++;
    endtask

    // Mostly clean packets; a quarter damaged in one field, a tenth plain noise.
    task automatic send_random_frame();
        int          kind;
        int          plen;
        int          n;
        bit          steady;
        logic [15:0] flip;
        kind   = $urandom_range(0, 99);
        plen   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        steady = ($urandom_range(0, 4) == 0);
        if (kind < 10)
        begin
            n = $urandom_range(1, 12);
            frame.delete();
            repeat (n) frame.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) frame[0] = cur_magic;
        end
        else
        begin
            build_frame(cur_magic, plen, $urandom_range(0, 9) < 6, 1'($urandom_range(0, 1)));
            if (kind < 35)
            begin
                case ($urandom_range(0, 5))
                    0: frame[0] ^= 8'($urandom_range(1, 255));
                    1: frame[1] |= 8'h01 << $urandom_range(0, 5);
                    2: frame[4 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
                    3: frame[6 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
                    4:
                    begin
                        flip = 16'($urandom_range(1, 65535));
                        frame[2] ^= flip[15:8];
                        frame[3] ^= flip[7:0];
                    end
                    default:
                    begin
                        // Truncate inside the header
                        n = $urandom_range(1, 7);
                        while (frame.size() > n) void'(frame.pop_back());
                    end
                endcase
            end
        end
        send_frame(steady);
    endtask

    // Drop the byte valid, drain all verdicts, let the pipeline settle, then write magic.
    task automatic write_magic(input logic [7:0] v);
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.magic_value <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_magic = v;
    endtask

    // Main sequence
    initial
    begin
        logic [7:0]  settings [5];
        sb = new();
        rst_n              = 1'b0;
        pkt_ch.valid       = 1'b0;
        pkt_ch.packet_byte = '0;
        pkt_ch.last_byte   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.magic_value = '0;
        cur_magic          = MAGIC_RESET;
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom_range(0, 255));
        settings[3] = 8'($urandom_range(0, 255));
        settings[4] = MAGIC_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: clean odd-length packet with checksum, lone 0xFF tail
        build_frame(cur_magic, 1, 1'b1, 1'b1);
        frame[8] = 8'hFF;
        seal_checksum(cur_magic);
        send_frame(1'b0);
        // Wrong magic, single byte
        frame = {ZERO_BYTE};
        send_frame(1'b0);
        // Right magic, nothing else: too short
        frame = {cur_magic};
        send_frame(1'b0);
        // Options low bits set
        frame = {cur_magic, 8'hFF};
        send_frame(1'b0);
        // Nonzero padding, checksum off
        build_frame(cur_magic, 0, 1'b0, 1'b1);
        frame[7] = 8'hFF;
        send_frame(1'b0);
        // Checksum requested but header cut short
        frame = {cur_magic, 8'h40, ZERO_BYTE};
        send_frame(1'b0);

        for (int p = 0; p < 5; p++)
        begin
            write_magic(settings[p]);
            if (p == 1)
            begin
                // Hold off the receiver and pour in tiny packets so that the input stalls
                hold_left = HOLD_CYCLES;
                repeat (12)
                begin
                    frame = {cur_magic};
                    send_frame(1'b1);
                end
            end
            n_phase_loop(p);
        end

        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d packets over six magic settings, with random idles",
                 frames_sent);
        $display("  on both sides and a long verdict hold-off that stalled the input");
        $display("Verdicts by code: ok %0d, magic %0d, options %0d, checksum %0d,",
                 sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3]);
        $display("  padding %0d, length %0d", sb.code_hits[4], sb.code_hits[5]);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Random packets for one magic setting, until the phase has its share of bytes
    task automatic n_phase_loop(input int p);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) send_random_frame();
    endtask

endmodule

>>> sim.f
hw/rtl/phcv_pkg.sv
hw/rtl/phcv_ifs.sv
hw/rtl/packet_header_checksum_validator_core.sv
tb/testbench.sv
